[hdl/bts_pkg.sv]
`timescale 1ns / 1ps
package bts_pkg;
   localparam int MAX_TREES      = 64;
   localparam int NODES_PER_TREE = 256;
   localparam int NUM_FEATURES   = 32;
   localparam int MAX_DEPTH      = 16;
   localparam int FRAC_BITS      = 16;

   localparam int TREE_W  = 6;
   localparam int NODE_W  = 8;
   localparam int FEAT_W  = 5;
   localparam int ADDR_W  = TREE_W + NODE_W;
   localparam int DEPTH_W = 7;
   localparam int CNT_W   = 7;
   localparam int ACC_W   = 40;

   localparam logic [1:0] CMD_NODE    = 2'd0;
   localparam logic [1:0] CMD_FEATURE = 2'd1;
   localparam logic [1:0] CMD_PREDICT = 2'd2;
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNWRIT  = 2'd1;
   localparam logic [1:0] ST_DEPTH   = 2'd2;

   localparam logic CSR_TREES = 1'b0;
   localparam logic CSR_BASE  = 1'b1;

   localparam logic [31:0] BASE_RESET = (FRAC_BITS > 0) ? 32'(1 << (FRAC_BITS - 1)) : 32'd0;

   typedef struct packed {
      logic [1:0]        command;
      logic [TREE_W-1:0] tree_index;
      logic [NODE_W-1:0] node_index;
      logic              is_leaf;
      logic [FEAT_W-1:0] split_feature;
      logic [31:0]       node_value;
      logic [NODE_W-1:0] left_child;
      logic [NODE_W-1:0] right_child;
      logic [NODE_W-1:0] missing_child;
      logic [FEAT_W-1:0] feature_slot;
      logic [31:0]       feature_value;
      logic              feature_present;
   } cmd_type;
endpackage

[hdl/boosted_tree_ensemble_scorer_top.sv]
`timescale 1ns / 1ps
// channel | ports                | direction
// req     | req_valid/req_ready  | in, commands
// rsp     | rsp_valid/rsp_ready  | out, score and status
// csr     | csr_valid/csr_ready  | in, register writes
// Load commands write the node or feature table when the back end takes them.
// Predict visits each node as a registered node-table read, then a branch.
// After synchronous reset the back end clears all 16384 node-table entries;
// the two-entry queue takes requests then and while the back end walks.
// A result held by rsp_ready stalls the back end only once the next predict ends.
module boosted_tree_ensemble_scorer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_tree_index,
   input  logic [7:0]  req_node_index,
   input  logic        req_is_leaf,
   input  logic [4:0]  req_split_feature,
   input  logic signed [31:0] req_node_value,
   input  logic [7:0]  req_left_child,
   input  logic [7:0]  req_right_child,
   input  logic [7:0]  req_missing_child,
   input  logic [4:0]  req_feature_slot,
   input  logic signed [31:0] req_feature_value,
   input  logic        req_feature_present,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_score,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   bts_pkg::cmd_type in_cmd, q_cmd;
   logic q_valid, q_ready, busy;
   logic [6:0]  trees_ff;
   logic [31:0] base_ff;

   assign in_cmd = '{req_command, req_tree_index, req_node_index, req_is_leaf,
                     req_split_feature, req_node_value, req_left_child, req_right_child,
                     req_missing_child, req_feature_slot, req_feature_value,
                     req_feature_present};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trees_ff <= '0;
         base_ff  <= bts_pkg::BASE_RESET;
      end else if (csr_valid) begin
         if (csr_index == bts_pkg::CSR_TREES) trees_ff <= csr_data[6:0];
         else base_ff <= csr_data;
      end
   end

   bts_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

   bts_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .trees_in_use(trees_ff), .base_score(base_ff), .out_valid(rsp_valid),
      .out_ready(rsp_ready), .out_score(rsp_score), .out_status(rsp_status), .busy(busy));

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bts_pkg::ST_OK |-> rsp_score == 32'd0)
      else $error("error result with nonzero score");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score))
      else $error("result dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result pending while back end idle");
endmodule

[hdl/bts_front.sv]
`timescale 1ns / 1ps
// Accepts commands into a two-entry queue; drops command 3 at the door.
module bts_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bts_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_ready,
   output bts_pkg::cmd_type q_cmd
);
   bts_pkg::cmd_type mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && (in_cmd.command != bts_pkg::CMD_IGNORED);
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_cmd;
   end
endmodule

[hdl/bts_back.sv]
`timescale 1ns / 1ps
// Executes queued commands. Predict walks each node as a registered table
// read (S_READ), then a branch decision (S_EVAL).
// After reset the node table (written flag in bit 62) is cleared one entry
// per cycle before any command is taken.
module bts_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  bts_pkg::cmd_type q_cmd,
   input  logic [6:0]       trees_in_use,
   input  logic [31:0]      base_score,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [31:0]      out_score,
   output logic [1:0]       out_status,
   output logic             busy
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;
   localparam int TBL = bts_pkg::MAX_TREES * bts_pkg::NODES_PER_TREE;

   logic [62:0] node_mem [TBL];
   logic [31:0] feat_mem_ff [bts_pkg::NUM_FEATURES];
   logic [bts_pkg::NUM_FEATURES-1:0] fvalid_ff;

   logic [1:0]                   st_ff, st_in;
   logic [bts_pkg::CNT_W-1:0]    tree_ff, tree_in, ntree_ff, ntree_in;
   logic [bts_pkg::NODE_W-1:0]   node_ff, node_in;
   logic [bts_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic signed [bts_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [62:0] rd_ff;
   logic        ov_ff, ov_in;
   logic [31:0] sc_ff, sc_in;
   logic [1:0]  ss_ff, ss_in;
   logic        clr_ff, clr_in;
   logic [bts_pkg::ADDR_W-1:0] caddr_ff, caddr_in;
   logic [bts_pkg::ADDR_W-1:0] raddr, waddr;
   logic        take, fok, less, out_free;
   logic [bts_pkg::NODE_W-1:0] nxt;
   logic [31:0] fval;
   logic signed [bts_pkg::ACC_W-1:0] sum;

   assign q_ready    = (st_ff == S_IDLE) && !clr_ff;
   assign take       = q_valid && q_ready;
   assign out_free   = !ov_ff || out_ready;
   assign out_valid  = ov_ff;
   assign out_score  = sc_ff;
   assign out_status = ss_ff;
   assign busy       = (st_ff != S_IDLE) || ov_ff;
   assign raddr = {tree_ff[bts_pkg::TREE_W-1:0], node_ff};
   assign waddr = {q_cmd.tree_index, q_cmd.node_index};

   always_ff @(posedge clock) begin
      rd_ff <= node_mem[raddr];
      if (clr_ff) begin
         node_mem[caddr_ff] <= '0;
      end else if (take && q_cmd.command == bts_pkg::CMD_NODE) begin
         node_mem[waddr] <= {1'b1, q_cmd.is_leaf, q_cmd.split_feature, q_cmd.missing_child,
                             q_cmd.right_child, q_cmd.left_child, q_cmd.node_value};
      end
   end

   assign fval = feat_mem_ff[rd_ff[60:56]];
   assign fok  = fvalid_ff[rd_ff[60:56]];
   assign less = $signed(fval) < $signed(rd_ff[31:0]);
   assign nxt  = !fok ? rd_ff[55:48] : (less ? rd_ff[39:32] : rd_ff[47:40]);
   assign sum  = acc_ff + bts_pkg::ACC_W'($signed(rd_ff[31:0]));

   always_comb begin
      st_in = st_ff; tree_in = tree_ff; ntree_in = ntree_ff; node_in = node_ff;
      depth_in = depth_ff; acc_in = acc_ff; ov_in = ov_ff; sc_in = sc_ff; ss_in = ss_ff;
      caddr_in = caddr_ff + 1'b1;
      clr_in   = clr_ff && (caddr_ff != '1);
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (take && q_cmd.command == bts_pkg::CMD_PREDICT) begin
               ntree_in = (trees_in_use > 7'(bts_pkg::MAX_TREES)) ?
                          7'(bts_pkg::MAX_TREES) : trees_in_use;
               tree_in  = '0;
               node_in  = '0;
               depth_in = '0;
               acc_in   = bts_pkg::ACC_W'($signed(base_score));
               st_in    = S_DONE;
               if (ntree_in != '0) st_in = S_READ;
            end
         end
         S_READ: st_in = S_EVAL;
         S_EVAL: begin
            // error outcomes wait here until the output register is free
            if (!rd_ff[62]) begin
               if (out_free) begin
                  ss_in = bts_pkg::ST_UNWRIT; sc_in = '0; ov_in = 1'b1; st_in = S_IDLE;
               end
            end else if (rd_ff[61]) begin
               acc_in   = sum;
               tree_in  = tree_ff + 1'b1;
               node_in  = '0;
               depth_in = '0;
               st_in    = (tree_in == ntree_ff) ? S_DONE : S_READ;
            end else if (depth_ff >= 7'(bts_pkg::MAX_DEPTH)) begin
               if (out_free) begin
                  ss_in = bts_pkg::ST_DEPTH; sc_in = '0; ov_in = 1'b1; st_in = S_IDLE;
               end
            end else begin
               node_in  = nxt;
               depth_in = depth_ff + 1'b1;
               st_in    = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ss_in = bts_pkg::ST_OK;
               if (acc_ff > 40'sh007FFFFFFF) sc_in = 32'h7FFFFFFF;
               else if (acc_ff < -40'sh0080000000) sc_in = 32'h80000000;
               else sc_in = acc_ff[31:0];
               ov_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         ov_ff     <= 1'b0;
         fvalid_ff <= '0;
         clr_ff    <= 1'b1;
         caddr_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         ov_ff    <= ov_in;
         clr_ff   <= clr_in;
         caddr_ff <= caddr_in;
         if (take && q_cmd.command == bts_pkg::CMD_FEATURE)
            fvalid_ff[q_cmd.feature_slot] <= q_cmd.feature_present;
      end
      if (take && q_cmd.command == bts_pkg::CMD_FEATURE)
         feat_mem_ff[q_cmd.feature_slot] <= q_cmd.feature_value;
      tree_ff <= tree_in; ntree_ff <= ntree_in; node_ff <= node_in;
      depth_ff <= depth_in; acc_ff <= acc_in; sc_ff <= sc_in; ss_ff <= ss_in;
   end
endmodule
